// ===== sv/lsgld_pkg.sv =====
// Shared types and constants of the line-scan gradient line detector.
`default_nettype none

package lsgld_pkg;

  localparam int DEF_PIXELS     = 128;
  localparam int DEF_PIXEL_BITS = 16;

  localparam int PIX_PORT_W = 16;
  localparam int THR_W      = 16;
  localparam int STRIDE_W   = 7;
  localparam int MARGIN_W   = 6;
  localparam int POS_W      = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EDGE_THRESHOLD = 3'd0,
    REG_SAMPLE_STRIDE  = 3'd1,
    REG_CROP_MARGIN    = 3'd2,
    REG_DARK_LINE      = 3'd3,
    REG_CENTER_MODE    = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [THR_W-1:0]    edge_threshold;
    logic [STRIDE_W-1:0] sample_stride;
    logic [MARGIN_W-1:0] crop_margin;
    logic                dark_line;
    logic                center_mode;
  } cfg_t;

  typedef struct packed {
    logic             last;
    logic             found;
    logic [POS_W-1:0] position;
  } frame_result_t;

endpackage

`default_nettype wire

// ===== sv/lsgld_track.sv =====
// Frame gradient tracker: sample selection, strongest rise/fall and frame result.
`default_nettype none

module lsgld_track
  import lsgld_pkg::*;
#(
  parameter int PIXELS     = DEF_PIXELS,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [PIXEL_BITS-1:0] pixel,
  input  wire logic                  start,
  input  wire logic                  advance,
  input  wire cfg_t                  cfg,
  output frame_result_t              result
);

  localparam int CW   = $clog2(PIXELS);
  localparam int DW   = PIXEL_BITS + 1;
  localparam int SW   = ((CW > STRIDE_W) ? CW : STRIDE_W) + 2;
  localparam int CMPW = ((DW > THR_W + 1) ? DW : THR_W + 1) + 1;

  // frame state
  logic [CW-1:0]         pixel_count;
  logic [STRIDE_W-1:0]   stride_phase;
  logic [PIXEL_BITS-1:0] prior_sample;
  logic [CW-1:0]         prior_position;
  logic                  have_prior;
  logic signed [DW-1:0]  best_rise;
  logic [CW-1:0]         rise_position;
  logic signed [DW-1:0]  best_fall;
  logic [CW-1:0]         fall_position;
  logic                  have_difference;

  logic [CW-1:0]         cur_count;
  logic [STRIDE_W-1:0]   cur_phase;
  logic                  cur_have_prior;
  logic                  cur_have_diff;
  logic [STRIDE_W-1:0]   stride_eff;
  logic [SW-1:0]         win_end;
  logic                  in_window;
  logic                  is_sample;
  logic                  take_diff;
  logic [STRIDE_W:0]     phase_inc;
  logic [STRIDE_W-1:0]   phase_next;
  logic signed [DW-1:0]  diff;
  logic                  upd_rise;
  logic                  upd_fall;
  logic signed [DW-1:0]  best_rise_next;
  logic [CW-1:0]         rise_position_next;
  logic signed [DW-1:0]  best_fall_next;
  logic [CW-1:0]         fall_position_next;
  logic                  have_difference_next;
  logic signed [CMPW-1:0] rise_ext;
  logic signed [CMPW-1:0] fall_mag;
  logic signed [CMPW-1:0] thr_ext;
  logic                  rise_ok;
  logic                  fall_ok;
  logic [CW:0]           pos_sum;
  logic [CW-1:0]         mid_pos;
  logic                  is_last;

  // A frame start drops the partial frame and counts this pixel as pixel 0.
  assign cur_count      = start ? '0 : pixel_count;
  assign cur_phase      = start ? '0 : stride_phase;
  assign cur_have_prior = start ? 1'b0 : have_prior;
  assign cur_have_diff  = start ? 1'b0 : have_difference;

  assign stride_eff = (cfg.sample_stride == '0) ? STRIDE_W'(1) : cfg.sample_stride;

  // Sample must span a full stride inside the crop window.
  assign win_end   = SW'(cur_count) + SW'(stride_eff) + SW'(cfg.crop_margin);
  assign in_window = (SW'(cur_count) >= SW'(cfg.crop_margin)) && (win_end <= SW'(PIXELS));
  assign is_sample = in_window && (cur_phase == '0);
  assign take_diff = is_sample && cur_have_prior;

  assign phase_inc  = {1'b0, cur_phase} + (STRIDE_W + 1)'(1);
  assign phase_next = (phase_inc >= {1'b0, stride_eff}) ? '0 : phase_inc[STRIDE_W-1:0];

  assign diff = $signed({1'b0, pixel}) - $signed({1'b0, prior_sample});

  assign upd_rise = take_diff && (!cur_have_diff || (diff > best_rise));
  assign upd_fall = take_diff && (!cur_have_diff || (diff < best_fall));

  assign best_rise_next       = upd_rise ? diff : best_rise;
  assign rise_position_next   = upd_rise ? prior_position : rise_position;
  assign best_fall_next       = upd_fall ? diff : best_fall;
  assign fall_position_next   = upd_fall ? prior_position : fall_position;
  assign have_difference_next = cur_have_diff || take_diff;

  assign rise_ext = CMPW'(best_rise_next);
  assign fall_mag = -CMPW'(best_fall_next);
  assign thr_ext  = $signed(CMPW'(cfg.edge_threshold));
  assign rise_ok  = rise_ext >= thr_ext;
  assign fall_ok  = fall_mag >= thr_ext;

  assign pos_sum = {1'b0, rise_position_next} + {1'b0, fall_position_next};
  assign mid_pos = pos_sum[CW:1];

  assign is_last = cur_count >= CW'(PIXELS - 1);

  always_comb begin
    result.last     = is_last;
    result.found    = 1'b0;
    result.position = '0;
    if (have_difference_next) begin
      priority if (cfg.center_mode) begin
        if (rise_ok && fall_ok) begin
          result.found    = 1'b1;
          result.position = POS_W'(mid_pos);
        end
      end else if (cfg.dark_line) begin
        if (fall_ok) begin
          result.found    = 1'b1;
          result.position = POS_W'(fall_position_next);
        end
      end else begin
        if (rise_ok) begin
          result.found    = 1'b1;
          result.position = POS_W'(rise_position_next);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_count     <= '0;
      stride_phase    <= '0;
      have_prior      <= 1'b0;
      have_difference <= 1'b0;
    end else if (advance) begin
      if (is_last) begin
        pixel_count     <= '0;
        stride_phase    <= '0;
        have_prior      <= 1'b0;
        have_difference <= 1'b0;
      end else begin
        pixel_count     <= cur_count + CW'(1);
        stride_phase    <= in_window ? phase_next : cur_phase;
        have_prior      <= cur_have_prior || is_sample;
        have_difference <= have_difference_next;
      end
    end
  end

  // Values behind cleared flags are never looked at, so these hold no reset.
  always_ff @(posedge clk) begin
    if (advance) begin
      if (is_sample) begin
        prior_sample   <= pixel;
        prior_position <= cur_count;
      end
      best_rise     <= best_rise_next;
      rise_position <= rise_position_next;
      best_fall     <= best_fall_next;
      fall_position <= fall_position_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/line_scan_gradient_line_detector_top.sv =====
// Line-scan gradient line detector: top level with config, input and result registers.
// A frame's result enters the result register when its last pixel leaves the input register.
// Throughput: one pixel per cycle, except while a frame's last pixel waits on a stalled, full
// result register; the gradient compare and best-value update sit in one stage between the
// input register and the result register. Reset (rst, synchronous): clears frame counters and flags, empties both
// registers, and loads the configuration defaults (stride 1, all else 0).
`default_nettype none

module line_scan_gradient_line_detector_top
  import lsgld_pkg::*;
#(
  parameter int PIXELS     = DEF_PIXELS,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [PIX_PORT_W-1:0] pixel_value,
  input  wire logic                  frame_start,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       found,
  output logic [POS_W-1:0]           position
);

  cfg_t                  cfg;
  logic                  s1_valid;
  logic [PIXEL_BITS-1:0] s1_pixel;
  logic                  s1_start;
  logic                  s1_fire;
  logic                  out_free;
  logic                  in_accept;
  frame_result_t         res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.edge_threshold <= '0;
      cfg.sample_stride  <= STRIDE_W'(1);
      cfg.crop_margin    <= '0;
      cfg.dark_line      <= 1'b0;
      cfg.center_mode    <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_EDGE_THRESHOLD: cfg.edge_threshold <= cfg_data[THR_W-1:0];
        REG_SAMPLE_STRIDE:  cfg.sample_stride  <= cfg_data[STRIDE_W-1:0];
        REG_CROP_MARGIN:    cfg.crop_margin    <= cfg_data[MARGIN_W-1:0];
        REG_DARK_LINE:      cfg.dark_line      <= cfg_data[0];
        REG_CENTER_MODE:    cfg.center_mode    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Only the frame's last pixel needs room in the result register.
  assign out_free  = !out_valid || !out_stall;
  assign s1_fire   = s1_valid && (!res.last || out_free);
  assign in_stall  = s1_valid && !s1_fire;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_pixel <= pixel_value[PIXEL_BITS-1:0];
      s1_start <= frame_start;
    end
  end

  lsgld_track #(
    .PIXELS     (PIXELS),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_track (
    .clk     (clk),
    .rst     (rst),
    .pixel   (s1_pixel),
    .start   (s1_start),
    .advance (s1_fire),
    .cfg     (cfg),
    .result  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && res.last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && res.last) begin
      found    <= res.found;
      position <= res.position;
    end
  end

endmodule

`default_nettype wire

// ===== test/line_scan_gradient_line_detector_top_test.sv =====
// Self-checking testbench for the line-scan gradient line detector top level.
`default_nettype none

module line_scan_gradient_line_detector_top_test;
  import lsgld_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIXELS        = DEF_PIXELS;
  localparam int PIX_MAX       = (1 << PIX_PORT_W) - 1;
  localparam int DIRECTED_ROWS = 20;
  localparam int RANDOM_PIXELS = 1800;
  localparam int SETTLE_CYCLES = 8;

  localparam cfg_t BOOT_CFG = '{16'd0, 7'd1, 6'd0, 1'b0, 1'b0};

  typedef enum logic [2:0] {
    SHAPE_FLAT,
    SHAPE_STEP,
    SHAPE_BAND,
    SHAPE_RAMP,
    SHAPE_NOISE
  } scan_shape_t;

  // One stretch of pixels: a shape, its levels and how the stretch is framed.
  typedef struct {
    logic             set_cfg;
    cfg_t             cfg;
    scan_shape_t      shape;
    int               level_a;
    int               level_b;
    int               first;
    int               last;
    int               length;
    logic             mark_start;
    int               noise;
    logic             stray_starts;
    logic             typed;
    logic             exp_found;
    logic [POS_W-1:0] exp_pos;
  } scan_plan_t;

  typedef struct packed {
    logic [PIX_PORT_W-1:0] value;
    logic                  fs;
    logic                  typed;
    logic                  exp_found;
    logic [POS_W-1:0]      exp_pos;
  } pixel_item_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } line_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_EDGE_THRESHOLD;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [PIX_PORT_W-1:0] pixel_value = '0;
  logic                  frame_start = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  found;
  logic [POS_W-1:0]      position;

  line_scan_gradient_line_detector_top DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .pixel_value (pixel_value),
    .frame_start (frame_start),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .found       (found),
    .position    (position)
  );

  always #5 clk = ~clk;

  // Predictor state and the configuration it mirrors.
  cfg_t                line_cfg = BOOT_CFG;
  logic [POS_W-1:0]    scan_count;
  logic [STRIDE_W-1:0] stride_step;
  logic [PIX_PORT_W-1:0] last_sample;
  logic [POS_W-1:0]    last_sample_pos;
  logic                sample_held;
  logic signed [16:0]  peak_rise;
  logic [POS_W-1:0]    peak_rise_pos;
  logic signed [16:0]  peak_fall;
  logic [POS_W-1:0]    peak_fall_pos;
  logic                gradient_seen;

  pixel_item_t  pending_pixels [$];
  line_result_t expected_lines [$];
  pixel_item_t  driven;
  line_result_t want;
  int pixels_queued = 0;
  int pixels_accepted = 0;
  int lines_checked = 0;
  int mismatches = 0;
  int in_gap = 0;
  int in_calm = 0;
  int stall_left = 0;
  int out_calm = 0;

  scan_plan_t directed_plans [DIRECTED_ROWS] = '{
    // reset settings on a flat line: every gradient is zero and meets threshold zero
    '{1'b0, BOOT_CFG, SHAPE_FLAT, 'h1234, 0, 0, 0, 128, 1'b1, 0, 1'b0,
      1'b1, 1'b1, 7'd0},
    '{1'b1, '{16'hFFFF, 7'd1, 6'd0, 1'b0, 1'b0}, SHAPE_STEP, 0, 'hFFFF, 40, 0, 128, 1'b1,
      0, 1'b0, 1'b1, 1'b1, 7'd39},
    '{1'b1, '{16'hFFFF, 7'd1, 6'd0, 1'b1, 1'b0}, SHAPE_STEP, 'hFFFF, 0, 40, 0, 128, 1'b1,
      0, 1'b0, 1'b1, 1'b1, 7'd39},
    // one count short of the threshold
    '{1'b1, '{16'hFFFF, 7'd1, 6'd0, 1'b0, 1'b0}, SHAPE_STEP, 0, 'hFFFE, 40, 0, 128, 1'b1,
      0, 1'b0, 1'b1, 1'b0, 7'd0},
    // widest stride leaves a single sample
    '{1'b1, '{16'd0, 7'd127, 6'd0, 1'b0, 1'b0}, SHAPE_FLAT, 0, 0, 0, 0, 128, 1'b1,
      0, 1'b0, 1'b1, 1'b0, 7'd0},
    // window too narrow for any sample
    '{1'b1, '{16'd0, 7'd127, 6'd63, 1'b0, 1'b0}, SHAPE_FLAT, 'hFFFF, 0, 0, 0, 128, 1'b1,
      0, 1'b0, 1'b1, 1'b0, 7'd0},
    '{1'b1, '{16'd0, 7'd2, 6'd63, 1'b0, 1'b0}, SHAPE_FLAT, 500, 0, 0, 0, 128, 1'b1,
      0, 1'b0, 1'b1, 1'b0, 7'd0},
    '{1'b1, '{16'd0, 7'd1, 6'd63, 1'b0, 1'b0}, SHAPE_STEP, 100, 50000, 64, 0, 128, 1'b1,
      0, 1'b0, 1'b0, 1'b0, 7'd0},
    // stride zero behaves as one
    '{1'b1, '{16'd100, 7'd0, 6'd0, 1'b0, 1'b0}, SHAPE_STEP, 10, 5000, 77, 0, 128, 1'b1,
      0, 1'b0, 1'b0, 1'b0, 7'd0},
    '{1'b1, '{16'd0, 7'd64, 6'd0, 1'b0, 1'b0}, SHAPE_STEP, 1000, 2000, 64, 0, 128, 1'b1,
      0, 1'b0, 1'b0, 1'b0, 7'd0},
    '{1'b1, '{16'd1000, 7'd1, 6'd0, 1'b0, 1'b1}, SHAPE_BAND, 200, 9000, 30, 50, 128, 1'b1,
      0, 1'b0, 1'b0, 1'b0, 7'd0},
    '{1'b1, '{16'd1000, 7'd3, 6'd10, 1'b0, 1'b1}, SHAPE_BAND, 40000, 100, 60, 90, 128, 1'b1,
      0, 1'b0, 1'b0, 1'b0, 7'd0},
    '{1'b1, '{16'd500, 7'd2, 6'd5, 1'b1, 1'b0}, SHAPE_BAND, 30000, 2000, 70, 75, 128, 1'b1,
      0, 1'b0, 1'b0, 1'b0, 7'd0},
    // center mode with a rise and no fall
    '{1'b1, '{16'd500, 7'd1, 6'd0, 1'b0, 1'b1}, SHAPE_STEP, 0, 8000, 20, 0, 128, 1'b1,
      0, 1'b0, 1'b0, 1'b0, 7'd0},
    // equal gradients everywhere: the first one must win
    '{1'b1, '{16'd10, 7'd3, 6'd5, 1'b0, 1'b0}, SHAPE_RAMP, 100, 7, 0, 0, 128, 1'b1,
      0, 1'b0, 1'b0, 1'b0, 7'd0},
    // abandoned frame, then a fresh one
    '{1'b0, BOOT_CFG, SHAPE_BAND, 5000, 20000, 10, 20, 60, 1'b1,
      0, 1'b0, 1'b0, 1'b0, 7'd0},
    '{1'b0, BOOT_CFG, SHAPE_BAND, 20000, 3000, 50, 80, 128, 1'b1,
      200, 1'b0, 1'b0, 1'b0, 7'd0},
    // no frame start: the count wraps into this frame
    '{1'b0, BOOT_CFG, SHAPE_STEP, 3000, 60000, 90, 0, 128, 1'b0,
      0, 1'b0, 1'b0, 1'b0, 7'd0},
    '{1'b1, '{16'd32768, 7'd1, 6'd0, 1'b0, 1'b0}, SHAPE_NOISE, 0, 0, 0, 0, 128, 1'b1,
      0, 1'b0, 1'b0, 1'b0, 7'd0},
    '{1'b1, '{16'd4000, 7'd5, 6'd20, 1'b1, 1'b1}, SHAPE_NOISE, 0, 0, 0, 0, 128, 1'b1,
      0, 1'b1, 1'b0, 1'b0, 7'd0}
  };

  task automatic restart_scan();
    scan_count      = '0;
    stride_step     = '0;
    last_sample     = '0;
    last_sample_pos = '0;
    sample_held     = 1'b0;
    peak_rise       = '0;
    peak_rise_pos   = '0;
    peak_fall       = '0;
    peak_fall_pos   = '0;
    gradient_seen   = 1'b0;
  endtask

  // Advance the detector model by one accepted pixel; queue the line result it yields.
  task automatic scan_pixel(input pixel_item_t it);
    int stride;
    int window;
    int offset;
    int diff;
    int thr;
    logic rise_ok;
    logic fall_ok;
    line_result_t r;
    if (it.fs) restart_scan();
    stride = (line_cfg.sample_stride == '0) ? 1 : int'(line_cfg.sample_stride);
    window = PIXELS - 2 * int'(line_cfg.crop_margin);
    offset = int'(scan_count) - int'(line_cfg.crop_margin);
    if (offset >= 0 && window > 0 && offset + stride <= window) begin
      if (stride_step == '0) begin
        if (sample_held) begin
          diff = int'(it.value) - int'(last_sample);
          if (!gradient_seen || diff > int'(peak_rise)) begin
            peak_rise = 17'(diff);
            peak_rise_pos = last_sample_pos;
          end
          if (!gradient_seen || diff < int'(peak_fall)) begin
            peak_fall = 17'(diff);
            peak_fall_pos = last_sample_pos;
          end
          gradient_seen = 1'b1;
        end
        last_sample = it.value;
        last_sample_pos = scan_count;
        sample_held = 1'b1;
      end
      stride_step = (int'(stride_step) + 1 >= stride) ? '0 : stride_step + 1'b1;
    end
    if (int'(scan_count) == PIXELS - 1) begin
      r.found = 1'b0;
      r.position = '0;
      if (gradient_seen) begin
        thr = int'(line_cfg.edge_threshold);
        rise_ok = int'(peak_rise) >= thr;
        fall_ok = -int'(peak_fall) >= thr;
        if (line_cfg.center_mode) begin
          if (rise_ok && fall_ok) begin
            r.found = 1'b1;
            r.position = POS_W'((int'(peak_rise_pos) + int'(peak_fall_pos)) / 2);
          end
        end else if (line_cfg.dark_line) begin
          if (fall_ok) begin
            r.found = 1'b1;
            r.position = peak_fall_pos;
          end
        end else if (rise_ok) begin
          r.found = 1'b1;
          r.position = peak_rise_pos;
        end
      end
      if (it.typed) begin
        r.found = it.exp_found;
        r.position = it.exp_pos;
      end
      expected_lines.push_back(r);
      restart_scan();
    end else begin
      scan_count = scan_count + 1'b1;
    end
  endtask

  // Mostly short gaps, a few long ones, and now and then a calm stretch with none.
  function automatic int draw_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = int'($urandom_range(0, 99));
    if (r < 2) begin
      calm = int'($urandom_range(20, 200));
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return int'($urandom_range(1, 3));
    if (r < 98) return int'($urandom_range(4, 12));
    return int'($urandom_range(20, 60));
  endfunction

  function automatic logic [PIX_PORT_W-1:0] pixel_level(input scan_plan_t p, input int idx);
    int v;
    case (p.shape)
      SHAPE_FLAT: v = p.level_a;
      SHAPE_STEP: v = (idx < p.first) ? p.level_a : p.level_b;
      SHAPE_BAND: v = (idx >= p.first && idx <= p.last) ? p.level_b : p.level_a;
      SHAPE_RAMP: v = p.level_a + idx * p.level_b;
      default:    v = int'($urandom_range(0, PIX_MAX));
    endcase
    if (p.noise > 0) v += int'($urandom_range(0, p.noise));
    if (v > PIX_MAX) v = PIX_MAX;
    return PIX_PORT_W'(v);
  endfunction

  task automatic push_segment(input scan_plan_t p);
    pixel_item_t it;
    for (int i = 0; i < p.length; i++) begin
      it.value = pixel_level(p, i);
      it.fs = (i == 0 && p.mark_start) || (p.stray_starts && $urandom_range(0, 63) == 0);
      it.typed = p.typed && i == p.length - 1;
      it.exp_found = p.exp_found;
      it.exp_pos = p.exp_pos;
      pending_pixels.push_back(it);
      pixels_queued++;
    end
  endtask

  function automatic cfg_t random_cfg();
    cfg_t c;
    int r;
    r = int'($urandom_range(0, 9));
    if (r == 0) c.edge_threshold = '0;
    else if (r == 1) c.edge_threshold = 16'hFFFF;
    else if (r < 6) c.edge_threshold = THR_W'($urandom_range(0, 4000));
    else c.edge_threshold = THR_W'($urandom_range(0, PIX_MAX));
    r = int'($urandom_range(0, 9));
    if (r < 6) c.sample_stride = STRIDE_W'($urandom_range(0, 3));
    else if (r < 9) c.sample_stride = STRIDE_W'($urandom_range(4, 20));
    else c.sample_stride = STRIDE_W'($urandom_range(21, 127));
    r = int'($urandom_range(0, 9));
    if (r < 7) c.crop_margin = MARGIN_W'($urandom_range(0, 15));
    else if (r < 9) c.crop_margin = MARGIN_W'($urandom_range(16, 63));
    else c.crop_margin = '1;
    c.dark_line = 1'($urandom_range(0, 1));
    c.center_mode = 1'($urandom_range(0, 1));
    return c;
  endfunction

  // A band or step feature, a ramp or noise on random levels; some noise and broken frames.
  function automatic scan_plan_t random_plan();
    scan_plan_t p;
    int r;
    p.set_cfg = 1'b0;
    p.cfg = BOOT_CFG;
    p.typed = 1'b0;
    p.exp_found = 1'b0;
    p.exp_pos = '0;
    r = int'($urandom_range(0, 99));
    if (r < 55) p.shape = SHAPE_BAND;
    else if (r < 75) p.shape = SHAPE_STEP;
    else if (r < 82) p.shape = SHAPE_RAMP;
    else p.shape = SHAPE_NOISE;
    p.level_a = int'($urandom_range(0, PIX_MAX));
    p.level_b = int'($urandom_range(0, PIX_MAX));
    if (p.shape == SHAPE_RAMP) begin
      p.level_a = int'($urandom_range(0, 4000));
      p.level_b = int'($urandom_range(0, 500));
    end
    p.first = int'($urandom_range(0, PIXELS - 1));
    p.last = p.first + int'($urandom_range(0, 40));
    p.noise = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 3000))
                                          : int'($urandom_range(0, 40));
    p.stray_starts = (p.shape == SHAPE_NOISE) && ($urandom_range(0, 1) == 1);
    r = int'($urandom_range(0, 99));
    p.length = PIXELS;
    p.mark_start = 1'b1;
    if (r >= 80 && r < 88) p.mark_start = 1'b0;
    else if (r >= 88) p.length = int'($urandom_range(1, PIXELS - 1));
    return p;
  endfunction

  task automatic load_config(input cfg_t c);
    cfg_reg_t idx;
    logic [CFG_DATA_W-1:0] data;
    line_cfg = c;
    idx = idx.first();
    repeat (idx.num()) begin
      case (idx)
        REG_EDGE_THRESHOLD: data = CFG_DATA_W'(c.edge_threshold);
        REG_SAMPLE_STRIDE:  data = CFG_DATA_W'(c.sample_stride);
        REG_CROP_MARGIN:    data = CFG_DATA_W'(c.crop_margin);
        REG_DARK_LINE:      data = CFG_DATA_W'(c.dark_line);
        default:            data = CFG_DATA_W'(c.center_mode);
      endcase
      cfg_write <= 1'b1;
      cfg_index <= idx;
      cfg_data <= data;
      @(posedge clk);
      idx = idx.next();
    end
    cfg_write <= 1'b0;
  endtask

  // Wait until every pixel is in and every line result is out, then let the pipeline drain.
  task automatic settle();
    while (pixels_accepted != pixels_queued || expected_lines.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Pixel transaction side: predict on acceptance, hold while stalled.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        scan_pixel(driven);
        pixels_accepted++;
      end
      if (!(in_valid && in_stall)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_pixels.size() > 0) begin
          driven = pending_pixels.pop_front();
          in_valid <= 1'b1;
          pixel_value <= driven.value;
          frame_start <= driven.fs;
          in_gap = draw_gap(in_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result transaction side: compare against the oldest expectation, stall at random.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_lines.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected line result: found=%0d position=%0d", found, position);
          mismatches++;
        end else begin
          want = expected_lines.pop_front();
          if (found !== want.found || position !== want.position) begin
            if (mismatches < 10)
              $display("line result %0d: expected found=%0d position=%0d, got found=%0d position=%0d",
                       lines_checked, want.found, want.position, found, position);
            mismatches++;
          end
        end
        lines_checked++;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        stall_left = draw_gap(out_calm);
        out_stall <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  initial begin
    int directed_pixels;
    restart_scan();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int n = 0; n < DIRECTED_ROWS; n++) begin
      if (directed_plans[n].set_cfg) begin
        settle();
        load_config(directed_plans[n].cfg);
      end
      push_segment(directed_plans[n]);
    end
    settle();

    directed_pixels = pixels_queued;
    while (pixels_queued - directed_pixels < RANDOM_PIXELS) begin
      load_config(random_cfg());
      repeat ($urandom_range(1, 4)) push_segment(random_plan());
      settle();
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire
